/* design/assert_macros.svh */
// Assertion macros shared by the chunk tag cache RTL.
// Each macro checks on the rising edge of clk and is quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Two conditions that must never be true in the same cycle.
`define ASSERT_NEVER_BOTH(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !((a) && (b))) else $error(msg);

`endif

/* design/lct_pkg.sv */
// Package for the chunk tag cache: field widths, tag layout, FSM states,
// and the command structs passed between the controller and the memories.
`default_nettype none

package lct_pkg;

  localparam int LCT_ENTRIES  = 128;
  localparam int CHUNK_W      = 28;
  localparam int DIM_W        = 3;
  localparam int TAG_W        = CHUNK_W + DIM_W + CHUNK_W;
  localparam int SLOT_OUT_W   = 7;
  localparam int IN_TDATA_W   = ((TAG_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((SLOT_OUT_W + 7) / 8) * 8;

  // Operation carried in the input tuser
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_PURGE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lct_state_t;

  // Recency memory access strobes
  typedef struct packed {
    logic rd;
    logic wr;
  } lct_ord_cmd_t;

  // Tag memory access strobes
  typedef struct packed {
    logic rd;
    logic wr;
    logic purge;
  } lct_tag_cmd_t;

endpackage

`default_nettype wire

/* design/lct_order_mem.sv */
// Recency list memory: slot number held at each position, most recent first.
// Positions never written read back as their own index. Uses lct_pkg.
`default_nettype none

module lct_order_mem #(
  parameter int ENTRIES = lct_pkg::LCT_ENTRIES,
  parameter int SLOTW   = $clog2(ENTRIES)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire lct_pkg::lct_ord_cmd_t cmd,
  input  wire [SLOTW-1:0]          raddr,
  input  wire [SLOTW-1:0]          waddr,
  input  wire [SLOTW-1:0]          wdata,
  output logic [SLOTW-1:0]         rslot
);

  logic [SLOTW-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic [SLOTW-1:0] data_q;
  logic [SLOTW-1:0] pos_q;
  logic             written_q;

  // Storage array, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      data_q <= mem[raddr];
      pos_q  <= raddr;
    end
  end

  // Written flags stand in for the reset order
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (cmd.wr) begin
        written[waddr] <= 1'b1;
      end
      if (cmd.rd) begin
        written_q <= written[raddr];
      end
    end
  end

  assign rslot = written_q ? data_q : pos_q;

endmodule

`default_nettype wire

/* design/lct_tag_mem.sv */
// Tag memory with per-slot valid flags; purge drops every valid flag.
// Uses lct_pkg for the tag width and command struct.
`default_nettype none

module lct_tag_mem #(
  parameter int ENTRIES = lct_pkg::LCT_ENTRIES,
  parameter int SLOTW   = $clog2(ENTRIES)
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire lct_pkg::lct_tag_cmd_t cmd,
  input  wire [SLOTW-1:0]            raddr,
  input  wire [SLOTW-1:0]            waddr,
  input  wire [lct_pkg::TAG_W-1:0]   wdata,
  output logic [lct_pkg::TAG_W-1:0]  rtag,
  output logic                       rvalid
);

  logic [lct_pkg::TAG_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  // Tag array, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rtag <= mem[raddr];
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (cmd.purge) begin
        valid <= '0;
      end else if (cmd.wr) begin
        valid[waddr] <= 1'b1;
      end
      if (cmd.rd) begin
        rvalid <= valid[raddr];
      end
    end
  end

endmodule

`default_nettype wire

/* design/lru_chunk_tag_cache.sv */
// Fully associative chunk tag cache with true LRU replacement.
// Depends on lct_pkg, lct_order_mem, lct_tag_mem and assert_macros.svh.
//
// Input stream: tuser is the operation (lookup/allocate or purge), tdata is
// the chunk coordinates and dimension that form the tag. Output stream: tuser
// is hit, tdata the slot. Exactly one output transfer per input transfer.
// A lookup walks the recency list from most recent, one position per cycle,
// through the recency memory and then the tag memory (each a registered
// read), and rewrites the list as it goes. A hit ends the walk at its
// position; a miss walks to the end of the list and retags the least recent
// slot. A purge goes straight to the result. One item is in work at a time;
// the next input is taken as soon as the result sits in the output register,
// even while the receiver stalls. A finished result waits for the output
// register to drain before the block goes idle again.
// Reset clears all valid flags and restores the list to slot i at position i,
// with no clearing pass; the block is ready on the cycle after reset.
`default_nettype none
`include "assert_macros.svh"

module lru_chunk_tag_cache #(
  parameter int ENTRIES = lct_pkg::LCT_ENTRIES
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // chunk_x[27:0], chunk_z[55:28], dimension[58:56], zero pad
  input  wire [lct_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func[0]
  input  wire                               s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // slot[6:0], zero pad
  output logic [lct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // hit[0]
  output logic                              m_axis_tuser
);

  localparam int SLOTW = $clog2(ENTRIES);
  localparam int EXTW  = (SLOTW > lct_pkg::SLOT_OUT_W) ? SLOTW : lct_pkg::SLOT_OUT_W;
  localparam logic [SLOTW-1:0] LAST_POS = SLOTW'(ENTRIES - 1);

  lct_pkg::lct_state_t state, state_next;

  logic [lct_pkg::TAG_W-1:0] tag;
  logic             iss;
  logic [SLOTW-1:0] rd_pos;
  logic             b_vld;
  logic             c_vld;
  logic [SLOTW-1:0] slot_c;
  logic [SLOTW-1:0] cmp_pos;
  logic [SLOTW-1:0] carry;
  logic [SLOTW-1:0] front_slot;
  logic             res_hit;
  logic             do_front;
  logic                           out_hit;
  logic [lct_pkg::SLOT_OUT_W-1:0] out_slot;

  lct_pkg::lct_ord_cmd_t ord_cmd;
  lct_pkg::lct_tag_cmd_t tag_cmd;
  logic [SLOTW-1:0] ord_waddr;
  logic [SLOTW-1:0] ord_wdata;
  logic [SLOTW-1:0] ord_slot;
  logic [lct_pkg::TAG_W-1:0] tag_rd;
  logic             tag_rd_vld;

  logic in_xfer;
  logic hit_c;
  logic scan_done;
  logic out_load;
  logic scan_wr;
  logic front_wr;
  logic [EXTW-1:0] front_ext;

  lct_order_mem #(.ENTRIES(ENTRIES), .SLOTW(SLOTW)) u_order (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ord_cmd),
    .raddr (rd_pos),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .rslot (ord_slot)
  );

  lct_tag_mem #(.ENTRIES(ENTRIES), .SLOTW(SLOTW)) u_tags (
    .clk    (clk),
    .rst    (rst),
    .cmd    (tag_cmd),
    .raddr  (ord_slot),
    .waddr  (slot_c),
    .wdata  (tag),
    .rtag   (tag_rd),
    .rvalid (tag_rd_vld)
  );

  // Compare stage and handshake terms
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign hit_c     = tag_rd_vld && (tag_rd == tag);
  assign scan_done = (state == lct_pkg::ST_SCAN) && c_vld && (hit_c || cmp_pos == LAST_POS);
  assign out_load  = (state == lct_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign front_ext = EXTW'(front_slot);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lct_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = (s_axis_tuser == lct_pkg::FUNC_PURGE) ? lct_pkg::ST_DONE
                                                            : lct_pkg::ST_SCAN;
        end
      end
      lct_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = lct_pkg::ST_DONE;
        end
      end
      lct_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = lct_pkg::ST_IDLE;
        end
      end
      default: state_next = lct_pkg::ST_IDLE;
    endcase
  end

  // Memory strobes and addresses
  always_comb begin
    s_axis_tready = (state == lct_pkg::ST_IDLE);
    scan_wr  = (state == lct_pkg::ST_SCAN) && c_vld && (cmp_pos != '0);
    front_wr = (state == lct_pkg::ST_DONE) && do_front;
    ord_cmd.rd = (state == lct_pkg::ST_SCAN) && iss;
    ord_cmd.wr = scan_wr || front_wr;
    ord_waddr  = front_wr ? '0 : cmp_pos;
    ord_wdata  = front_wr ? front_slot : carry;
    tag_cmd.rd    = (state == lct_pkg::ST_SCAN) && b_vld;
    tag_cmd.wr    = scan_done && !hit_c;
    tag_cmd.purge = in_xfer && (s_axis_tuser == lct_pkg::FUNC_PURGE);
  end

  // Scan pipeline: issue position, read slot, read tag, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lct_pkg::ST_IDLE;
      iss   <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lct_pkg::ST_SCAN) begin
        b_vld <= iss;
        c_vld <= b_vld;
        if (iss && rd_pos == LAST_POS) begin
          iss <= 1'b0;
        end
        if (scan_done) begin
          iss   <= 1'b0;
          b_vld <= 1'b0;
          c_vld <= 1'b0;
        end
      end else if (in_xfer && s_axis_tuser == lct_pkg::FUNC_LOOKUP) begin
        iss <= 1'b1;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tag      <= s_axis_tdata[lct_pkg::TAG_W-1:0];
      rd_pos   <= '0;
      cmp_pos  <= '0;
      do_front <= (s_axis_tuser == lct_pkg::FUNC_LOOKUP);
      res_hit  <= 1'b0;
      front_slot <= '0;
    end else if (state == lct_pkg::ST_SCAN) begin
      if (iss) begin
        rd_pos <= rd_pos + 1'b1;
      end
      slot_c <= ord_slot;
      if (c_vld) begin
        carry   <= slot_c;
        cmp_pos <= cmp_pos + 1'b1;
      end
      if (scan_done) begin
        front_slot <= slot_c;
        res_hit    <= hit_c;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit  <= res_hit;
      out_slot <= front_ext[lct_pkg::SLOT_OUT_W-1:0];
    end
  end

  assign m_axis_tuser = out_hit;
  assign m_axis_tdata = lct_pkg::OUT_TDATA_W'(out_slot);

  // A miss is only decided at the least recent position
  `ASSERT_CLK(a_miss_at_tail, (scan_done && !hit_c) |-> (cmp_pos == LAST_POS), "miss before tail")
  // The compare-stage write and the front write never collide
  `ASSERT_NEVER_BOTH(a_ord_wr_excl, scan_wr, front_wr, "two recency writes")
  // A result is loaded only into a free or draining output register
  `ASSERT_CLK(a_out_free, out_load |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  // Purge never overlaps a tag write
  `ASSERT_NEVER_BOTH(a_purge_wr, tag_cmd.purge, tag_cmd.wr, "purge during retag")

endmodule

`default_nettype wire
